// ===== src/srmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Shared radio medium carrier model package
// Types and constants shared by the carrier model cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package srmc_pkg;

	// Field widths of the input and configuration transactions.
	localparam int NODE_W     = 4;
	localparam int CNT_W      = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	// Number of nodes that the node field can name.
	localparam int NODE_SPAN = 2 ** NODE_W;

	// Saturation limit of an activity counter.
	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	// Reset value of the node count register.
	localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RST = 5'd16;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_TX   = 2'd0,
		REQ_STOP = 2'd1,
		REQ_HEAR = 2'd2,
		REQ_LINK = 2'd3
	} req_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODE_COUNT = 1'd0,
		CFG_FULL_MESH  = 1'd1
	} cfg_idx_t;

	// Counter update command that travels down the row of cells.
	typedef struct packed {
		logic                  valid;
		logic                  up;
		logic                  mesh;
		logic [CFG_DATA_W-1:0] lim;
		logic [NODE_W-1:0]     from;
	} cmd_t;

	// Broadcast writes of flags and link bits, applied by every cell in the same cycle.
	typedef struct packed {
		logic              link_we;
		logic              flag_we;
		logic              flag_val;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
	} ctl_t;

endpackage

`default_nettype wire

// ===== src/srmc_cell.sv =====
// ----------------------------------------------------------------------------
// Carrier model cell
// Holds one node's activity counter, transmit flag and link row, applies the
// passing update command and hands it to the next cell through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module srmc_cell #(
	parameter int IDX   = 0,
	parameter int CELLS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  srmc_pkg::cmd_t     cmd_in,
	input  srmc_pkg::ctl_t     ctl,
	output srmc_pkg::cmd_t     cmd_out,
	output logic               flag,
	output logic               active
);
	import srmc_pkg::*;

	localparam int IDXW = $clog2(CELLS);
	localparam logic [NODE_W-1:0]     ME_NODE = NODE_W'(IDX);
	localparam logic [CFG_DATA_W-1:0] ME_LIM  = CFG_DATA_W'(IDX);

	logic [CNT_W-1:0] cnt_q;
	logic             flag_q;
	logic [CELLS-1:0] link_q;
	cmd_t             cmd_q;
	logic             hit;
	logic             link_hit;
	logic [IDXW-1:0]  link_far;

	// This node is updated when it is live and reached by the sender.
	assign hit = cmd_in.valid && (ME_LIM < cmd_in.lim) &&
		(cmd_in.mesh || link_q[cmd_in.from[IDXW-1:0]]);

	// A link touches this node at either end; the far end picks the row bit.
	assign link_hit = ctl.link_we && (ctl.a == ME_NODE || ctl.b == ME_NODE);
	assign link_far = (ctl.a == ME_NODE) ? ctl.b[IDXW-1:0] : ctl.a[IDXW-1:0];

	// Saturating activity counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (hit) begin
			if (cmd_in.up) begin
				if (cnt_q != CNT_MAX) cnt_q <= cnt_q + 1'b1;
			end else begin
				if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Transmit flag and symmetric link row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			link_q <= '0;
		end else begin
			if (ctl.flag_we && ctl.a == ME_NODE) flag_q <= ctl.flag_val;
			if (link_hit) link_q[link_far] <= 1'b1;
		end
	end

	// Hand the command to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
		end else begin
			cmd_q <= cmd_in;
		end
	end

	assign cmd_out = cmd_q;
	assign flag    = flag_q;
	assign active  = (cnt_q != '0);

endmodule

`default_nettype wire

// ===== src/shared_radio_medium_carrier_model_core.sv =====
// ----------------------------------------------------------------------------
// Shared radio medium carrier model
// Per node activity counters, transmit flags and a symmetric link map, kept
// in a row of cells that a counter update command walks through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries req_type, node, tx_bit, peer.
//   Output channel (out_valid / out_stall) carries heard, one transaction for
//   each hear query, in order.
//   Configuration registers (node_count, full_mesh) are written through
//   cfg_we / cfg_index / cfg_wdata while the block is idle.
// Flow of transactions:
//   Hear, link and flag-only transactions leave the input free for the next
//   transaction unless the output stalls; a hear result is in the output
//   register in the cycle after acceptance. A transmit of a one bit, or a stop
//   of a transmitting node, starts an update command that moves one cell per
//   cycle through min(NODES, 16) cells; no further transaction is accepted
//   until the sweep length counter has run out.
// Reset clears all counters, flags and links and sets node_count to 16 and
// full_mesh to 0. While the output register holds a result that the receiver
// stalls, in_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_radio_medium_carrier_model_core #(
	parameter int NODES = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [srmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [srmc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [1:0]                          req_type,
	input  wire  [srmc_pkg::NODE_W-1:0]         node,
	input  wire                                 tx_bit,
	input  wire  [srmc_pkg::NODE_W-1:0]         peer,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                heard
);
	import srmc_pkg::*;

	localparam int CELLS = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
	localparam int IDXW  = $clog2(CELLS);
	localparam int SCW   = $clog2(CELLS + 1);
	localparam logic [SCW-1:0] SWEEP_LEN = SCW'(CELLS);

	logic [CFG_DATA_W-1:0] node_count_q;
	logic                  full_mesh_q;
	logic [SCW-1:0]        sweep_cnt_q;
	cmd_t                  inj_q;
	logic                  out_valid_q;
	logic                  heard_q;

	cmd_t                  chain [CELLS+1];
	logic [CELLS-1:0]      flag_w;
	logic [CELLS-1:0]      active_w;
	logic [CELLS:0]        chain_valid;

	logic                  accept;
	logic                  node_ok;
	logic                  peer_ok;
	logic                  start_sweep;
	logic                  sweep_up;
	ctl_t                  ctl;

	// Input handshake.
	assign in_stall = (sweep_cnt_q != '0) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign node_ok  = (32'(node) < NODES);
	assign peer_ok  = (32'(peer) < NODES);

	// Decode of an accepted transaction.
	always_comb begin
		ctl          = '0;
		ctl.a        = node;
		ctl.b        = peer;
		start_sweep  = 1'b0;
		sweep_up     = 1'b0;
		if (accept) begin
			case (req_t'(req_type))
				REQ_TX: begin
					if (node_ok) begin
						ctl.flag_we  = 1'b1;
						ctl.flag_val = tx_bit;
						start_sweep  = tx_bit;
						sweep_up     = 1'b1;
					end
				end
				REQ_STOP: begin
					if (node_ok && flag_w[node[IDXW-1:0]]) begin
						ctl.flag_we  = 1'b1;
						ctl.flag_val = 1'b0;
						start_sweep  = 1'b1;
					end
				end
				REQ_LINK: begin
					ctl.link_we = node_ok && peer_ok;
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			full_mesh_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NODE_COUNT: node_count_q <= cfg_wdata;
				CFG_FULL_MESH:  full_mesh_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Command injection and sweep length counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q       <= '0;
			sweep_cnt_q <= '0;
		end else begin
			inj_q.valid <= start_sweep;
			inj_q.up    <= sweep_up;
			inj_q.mesh  <= full_mesh_q;
			inj_q.lim   <= node_count_q;
			inj_q.from  <= node;
			if (start_sweep) begin
				sweep_cnt_q <= SWEEP_LEN;
			end else if (sweep_cnt_q != '0) begin
				sweep_cnt_q <= sweep_cnt_q - 1'b1;
			end
		end
	end

	// Row of cells.
	assign chain[0] = inj_q;
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		srmc_cell #(
			.IDX   (i),
			.CELLS (CELLS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd_in  (chain[i]),
			.ctl     (ctl),
			.cmd_out (chain[i+1]),
			.flag    (flag_w[i]),
			.active  (active_w[i])
		);
	end

	for (genvar j = 0; j <= CELLS; j++) begin : g_cv
		assign chain_valid[j] = chain[j].valid;
	end

	// Output register for hear results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && req_t'(req_type) == REQ_HEAR) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_t'(req_type) == REQ_HEAR) begin
			heard_q <= node_ok && active_w[node[IDXW-1:0]];
		end
	end

	assign out_valid = out_valid_q;
	assign heard     = heard_q;

`ifndef NO_ASSERTIONS
	// At most one update command is in flight in the row.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_valid))
		else $error("more than one update command in the cell row");

	// The command leaves the last cell exactly when the sweep count runs out.
	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[CELLS] |-> sweep_cnt_q == '0)
		else $error("update command still in flight after sweep end");

	// A started sweep loads the full sweep length.
	a_sweep_load: assert property (@(posedge clk) disable iff (!arst_n)
		start_sweep |=> sweep_cnt_q == SWEEP_LEN && inj_q.valid)
		else $error("sweep start did not load counter and command");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shared radio medium carrier model testbench
// Drives transmit, stop, hear and link transactions into the carrier model
// core with random gaps on both channels and under several register settings.
// A scoreboard keeps its own copy of the counters, flags and link map. It
// checks every heard result against the oldest expected value.
// ----------------------------------------------------------------------------

module tb_top;
	import srmc_pkg::*;

	localparam int NODES = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 100;

	// Scoreboard: shadow copy of the channel state and the queue of heard values.
	class carrier_scoreboard;
		logic [CNT_W-1:0]      activity [NODES];
		bit                    sending [NODES];
		bit [NODES-1:0]        links [NODES];
		logic [CFG_DATA_W-1:0] node_count;
		bit                    full_mesh;
		bit                    heard_due [$];
		int                    errors;

		function new();
			for (int i = 0; i < NODES; i++) begin
				activity[i] = '0;
				sending[i] = 1'b0;
				links[i] = '0;
			end
			node_count = NODE_COUNT_RST;
			full_mesh = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_NODE_COUNT: node_count = val;
				CFG_FULL_MESH: full_mesh = val[0];
				default: ;
			endcase
		endfunction

		// Add one to, or take one from, every live node that the source reaches.
		function void spread_activity(int src, bit up);
			int lim;
			lim = (node_count > NODES) ? NODES : int'(node_count);
			for (int i = 0; i < lim; i++) begin
				if (full_mesh || links[src][i]) begin
					if (up && activity[i] != CNT_MAX)
						activity[i] = activity[i] + 1'b1;
					else if (!up && activity[i] != '0)
						activity[i] = activity[i] - 1'b1;
				end
			end
		endfunction

		// Apply one accepted input transaction to the shadow state.
		function void note_request(req_t kind, int n, bit b, int p);
			case (kind)
				REQ_TX: begin
					if (n < NODES) begin
						sending[n] = b;
						if (b)
							spread_activity(n, 1'b1);
					end
				end
				REQ_STOP: begin
					if (n < NODES && sending[n]) begin
						sending[n] = 1'b0;
						spread_activity(n, 1'b0);
					end
				end
				REQ_HEAR: heard_due.push_back(n < NODES && activity[n] != '0);
				REQ_LINK: begin
					if (n < NODES && p < NODES) begin
						links[n][p] = 1'b1;
						links[p][n] = 1'b1;
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one output transaction with the oldest expected value.
		function void check_heard(logic h);
			bit want;
			if (heard_due.size() == 0) begin
				$error("heard: unexpected result, actual %0b", h);
				errors++;
			end else begin
				want = heard_due.pop_front();
				if (h !== want) begin
					$error("heard: expected %0b, actual %0b", want, h);
					errors++;
				end
			end
		endfunction

		// A random node whose flag matches, or any node when none does.
		function int pick_node(bit flag_wanted);
			int hits [$];
			for (int i = 0; i < NODES; i++)
				if (sending[i] == flag_wanted)
					hits.push_back(i);
			if (hits.size() == 0)
				return $urandom_range(NODES - 1);
			return hits[$urandom_range(hits.size() - 1)];
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = CFG_NODE_COUNT;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            req_type = REQ_TX;
	logic [NODE_W-1:0]     node = '0;
	logic                  tx_bit = 1'b0;
	logic [NODE_W-1:0]     peer = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  heard;

	// When set, neither side inserts gaps or stalls.
	bit calm = 1'b0;

	carrier_scoreboard sb;

	shared_radio_medium_carrier_model_core #(
		.NODES(NODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.node(node),
		.tx_bit(tx_bit),
		.peer(peer),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.heard(heard)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver side stalls at random.
	initial begin
		forever begin
			@(posedge clk);
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
		end
	end

	// Check every output transaction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_heard(heard);
	end

	// Send one transaction, with random idle cycles ahead of it.
	task automatic send_request(req_t kind, int n, bit b, int p);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		node <= n[NODE_W-1:0];
		tx_bit <= b;
		peer <= p[NODE_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(kind, n, b, p);
	endtask

	// Wait until every heard result is in and any counter walk has ended.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.heard_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_mode(int cnt, bit mesh);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[0] = mesh;
		program_reg(CFG_NODE_COUNT, cnt[CFG_DATA_W-1:0]);
		program_reg(CFG_FULL_MESH, d);
		cfg_we <= 1'b0;
	endtask

	// Random traffic: mostly transmit and stop pairs, some hears and links, some noise.
	task automatic run_traffic(int count, int tx_share);
		int r;
		int n;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_request(REQ_LINK, $urandom_range(NODES - 1), 1'($urandom_range(1)),
					$urandom_range(NODES - 1));
			end else if (r < 30) begin
				send_request(REQ_HEAR, $urandom_range(NODES - 1), 1'($urandom_range(1)),
					$urandom_range(15));
			end else if (r < 30 + tx_share) begin
				if ($urandom_range(99) < 85)
					send_request(REQ_TX, sb.pick_node(1'b0), 1'b1, $urandom_range(15));
				else
					send_request(REQ_TX, $urandom_range(NODES - 1), 1'($urandom_range(1)),
						$urandom_range(15));
			end else begin
				n = ($urandom_range(99) < 80) ? sb.pick_node(1'b1) : $urandom_range(NODES - 1);
				send_request(REQ_STOP, n, 1'($urandom_range(1)), $urandom_range(15));
			end
		end
	endtask

	// Main sequence.
	initial begin
		int counts [PHASES];
		bit meshes [PHASES];
		int tx_shares [PHASES];
		counts = '{16, 31, 0, 1, 17, 16, 5, 12};
		meshes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		tx_shares = '{28, 60, 28, 28, 28, 40, 28, 28};
		meshes[7] = 1'($urandom_range(1));

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks under the reset settings.
		send_request(REQ_HEAR, 0, 1'b0, 0);
		send_request(REQ_TX, 5, 1'b1, 15);      // no links yet, nothing reached
		send_request(REQ_HEAR, 5, 1'b1, 15);
		send_request(REQ_LINK, 5, 1'b0, 5);     // a node linked to itself
		send_request(REQ_LINK, 3, 1'b1, 15);
		send_request(REQ_TX, 15, 1'b1, 0);
		send_request(REQ_HEAR, 3, 1'b0, 0);
		send_request(REQ_HEAR, 15, 1'b0, 0);
		send_request(REQ_LINK, 15, 1'b0, 7);
		send_request(REQ_STOP, 15, 1'b0, 0);    // node 7 counter stays at zero
		send_request(REQ_HEAR, 7, 1'b0, 0);
		send_request(REQ_HEAR, 3, 1'b0, 0);
		send_request(REQ_STOP, 15, 1'b1, 15);   // not transmitting, no change
		send_request(REQ_TX, 5, 1'b1, 0);       // repeated transmit counts again
		send_request(REQ_TX, 5, 1'b1, 0);
		send_request(REQ_STOP, 5, 1'b0, 0);
		send_request(REQ_HEAR, 5, 1'b0, 0);
		send_request(REQ_TX, 5, 1'b0, 15);      // zero bit clears the flag only
		send_request(REQ_STOP, 5, 1'b0, 0);
		send_request(REQ_HEAR, 5, 1'b1, 0);
		send_request(REQ_LINK, 0, 1'b1, 15);
		send_request(REQ_TX, 0, 1'b1, 0);
		send_request(REQ_HEAR, 15, 1'b0, 15);
		send_request(REQ_STOP, 0, 1'b1, 0);
		wait_idle();

		// Random phases, each under its own register settings.
		for (int ph = 0; ph < PHASES; ph++) begin
			set_mode(counts[ph], meshes[ph]);
			calm = (ph == 5);
			run_traffic(PHASE_ITEMS, tx_shares[ph]);
			wait_idle();
		end

		if (sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/srmc_pkg.sv
src/srmc_cell.sv
src/shared_radio_medium_carrier_model_core.sv
bench/tb_top.sv
